FILE: hdl/i2cseq_pkg.sv
// Package for the sensor transfer sequencer: codes, phases, bus address bytes
// and the state and result structs shared by the step logic and the top level.
// No dependencies.
package i2cseq_pkg;

    // Item kinds
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_EVENT = 1'b1;

    // Operation codes (any other code aborts the transfer)
    localparam logic [3:0] OP_WRITE     = 4'h0;
    localparam logic [3:0] OP_CUR_READ  = 4'h1;
    localparam logic [3:0] OP_RAND_READ = 4'h2;

    // Phase nibble; each step sets one more bit, bit 3 marks the end
    localparam logic [3:0] PH_IDLE  = 4'h0;
    localparam logic [3:0] PH_ADDR  = 4'h1;
    localparam logic [3:0] PH_DATA  = 4'h3;
    localparam logic [3:0] PH_LAST  = 4'h7;
    localparam logic [3:0] PH_FIN   = 4'hf;
    localparam logic [3:0] PH_ABORT = 4'h8;

    // Fixed 7-bit sensor address and the address bytes that carry it
    localparam logic [6:0] DEV_ADDR = 7'h48;
    localparam logic [7:0] ADDR_WR  = {DEV_ADDR, 1'b0};
    localparam logic [7:0] ADDR_RD  = {DEV_ADDR, 1'b1};

    typedef struct packed {
        logic [3:0]  phase;
        logic [3:0]  op;
        logic [7:0]  addr;
        logic [7:0]  data;
        logic [15:0] rd;
    } seq_state_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        ctl_valid;
        logic        start_bit;
        logic        stop_bit;
        logic        ack_valid;
        logic        ack_bit;
        logic [15:0] read_value;
        logic        done_res;
    } seq_res_t;

endpackage

FILE: hdl/i2c_sensor_transfer_sequencer.sv
// Top level of the sensor transfer sequencer: input handshake, sequencer
// state and the registered result stage. Depends on i2cseq_pkg, i2cseq_step.
//
// Usage
//   Input channel (in_valid / in_stall): each word is either a command load
//   (action 0: op_code, word_addr, write_data) or a bus event report
//   (action 1: rx_byte). Every input word gives exactly one result word.
//   Output channel (out_valid / out_stall): the bus drive for that word
//   (byte to send, start/stop, acknowledge), the assembled 16-bit read
//   value and the done flag.
//   The result is registered; it appears in the cycle after acceptance.
//   Throughput: one word per cycle when not stalled, set by the single result
//   register; state update and drive decode are one short pass of case logic.
//   Stall: while a result waits under out_stall, in_stall is raised and the
//   sequencer state holds; as soon as the result is taken a new word may
//   enter in the same cycle.
//   Reset: rst_n clears the sequencer state to zero (byte write, idle phase)
//   and empties the result register.
module i2c_sensor_transfer_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [3:0]  op_code,
    input  logic [7:0]  word_addr,
    input  logic [7:0]  write_data,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        ctl_valid,
    output logic        start_bit,
    output logic        stop_bit,
    output logic        ack_valid,
    output logic        ack_bit,
    output logic [15:0] read_value,
    output logic        done_res
);
    import i2cseq_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;
    seq_res_t   res_reg;
    seq_res_t   res_next;
    logic       out_valid_reg;
    logic       in_take;

    // Hold the input only while a finished result is still waiting
    assign in_stall = out_valid_reg & out_stall;
    assign in_take  = in_valid & ~in_stall;

    i2cseq_step u_step
    (
        .cur        (state_reg),
        .action     (action),
        .op_code    (op_code),
        .word_addr  (word_addr),
        .write_data (write_data),
        .rx_byte    (rx_byte),
        .nxt        (state_next),
        .res        (res_next)
    );

    // Sequencer state: advance on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_take)
        begin
            state_reg <= state_next;
        end
    end

    // Result valid: set on acceptance, drop once taken with nothing new behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: load with each accepted word, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tx_valid   = res_reg.tx_valid;
    assign tx_byte    = res_reg.tx_byte;
    assign ctl_valid  = res_reg.ctl_valid;
    assign start_bit  = res_reg.start_bit;
    assign stop_bit   = res_reg.stop_bit;
    assign ack_valid  = res_reg.ack_valid;
    assign ack_bit    = res_reg.ack_bit;
    assign read_value = res_reg.read_value;
    assign done_res   = res_reg.done_res;

endmodule

FILE: hdl/i2cseq_step.sv
// Step logic of the sensor transfer sequencer: next state and bus drive for
// one word, purely combinational. Depends on i2cseq_pkg.
module i2cseq_step
(
    input  i2cseq_pkg::seq_state_t cur,
    input  logic                   action,
    input  logic [3:0]             op_code,
    input  logic [7:0]             word_addr,
    input  logic [7:0]             write_data,
    input  logic [7:0]             rx_byte,
    output i2cseq_pkg::seq_state_t nxt,
    output i2cseq_pkg::seq_res_t   res
);
    import i2cseq_pkg::*;

    always_comb
    begin
        nxt = cur;
        res = '0;
        if (action == ACT_LOAD)
        begin
            nxt.op    = op_code;
            nxt.phase = PH_IDLE;
            nxt.addr  = word_addr;
            nxt.data  = write_data;
            nxt.rd    = '0;
        end
        else
        begin
            unique case (cur.op)
                OP_WRITE:
                begin
                    unique case (cur.phase)
                        PH_IDLE:
                        begin
                            res.ctl_valid = 1'b1;
                            res.tx_valid  = 1'b1;
                            res.tx_byte   = ADDR_WR;
                            nxt.phase     = PH_ADDR;
                        end
                        PH_ADDR:
                        begin
                            res.ctl_valid = 1'b1;
                            res.tx_valid  = 1'b1;
                            res.tx_byte   = cur.addr;
                            nxt.phase     = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            res.ctl_valid = 1'b1;
                            res.tx_valid  = 1'b1;
                            res.tx_byte   = cur.data;
                            nxt.phase     = PH_LAST;
                        end
                        PH_LAST:
                        begin
                            res.ctl_valid = 1'b1;
                            res.stop_bit  = 1'b1;
                            nxt.phase     = PH_FIN;
                        end
                        default:
                        begin
                            nxt = cur;
                        end
                    endcase
                end
                OP_CUR_READ:
                begin
                    unique case (cur.phase)
                        PH_IDLE:
                        begin
                            res.ctl_valid = 1'b1;
                            res.tx_valid  = 1'b1;
                            res.tx_byte   = ADDR_RD;
                            nxt.phase     = PH_ADDR;
                        end
                        PH_ADDR:
                        begin
                            res.ctl_valid = 1'b1;
                            res.ack_valid = 1'b1;
                            res.ack_bit   = 1'b1;
                            nxt.phase     = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            // first byte received lands in the upper half
                            res.ctl_valid = 1'b1;
                            res.ack_valid = 1'b1;
                            res.ack_bit   = 1'b1;
                            nxt.phase     = PH_LAST;
                            nxt.rd        = {rx_byte, cur.rd[7:0]};
                        end
                        PH_LAST:
                        begin
                            res.ctl_valid = 1'b1;
                            res.stop_bit  = 1'b1;
                            res.ack_valid = 1'b1;
                            nxt.phase     = PH_FIN;
                            nxt.rd        = {cur.rd[15:8], rx_byte};
                        end
                        default:
                        begin
                            nxt = cur;
                        end
                    endcase
                end
                OP_RAND_READ:
                begin
                    unique case (cur.phase)
                        PH_IDLE:
                        begin
                            res.ctl_valid = 1'b1;
                            res.tx_valid  = 1'b1;
                            res.tx_byte   = ADDR_WR;
                            nxt.phase     = PH_ADDR;
                        end
                        PH_ADDR:
                        begin
                            res.ctl_valid = 1'b1;
                            res.tx_valid  = 1'b1;
                            res.tx_byte   = cur.addr;
                            nxt.phase     = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            // repeated start, then carry on as a current-address read
                            res.ctl_valid = 1'b1;
                            res.start_bit = 1'b1;
                            nxt.phase     = PH_IDLE;
                            nxt.op        = OP_CUR_READ;
                        end
                        default:
                        begin
                            nxt = cur;
                        end
                    endcase
                end
                default:
                begin
                    nxt.phase = PH_ABORT;
                    nxt.op    = OP_WRITE;
                end
            endcase
        end
        res.read_value = nxt.rd;
        res.done_res   = nxt.phase[3];
    end

endmodule

FILE: verif/tb.sv
// Self-checking testbench for i2c_sensor_transfer_sequencer: directed and
// random command/event words, predicted drives compared per field.
// Depends on i2cseq_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module tb;
    import i2cseq_pkg::*;

    // Codes outside the three known operations
    localparam logic [3:0] OP_BAD_HIGH = 4'hf;
    localparam logic [3:0] OP_BAD_LOW  = 4'h3;

    localparam int RANDOM_WORDS_PER_PHASE = 382;
    localparam int DRAIN_LIMIT            = 20000;
    localparam int SETTLE_CYCLES          = 8;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        action     = ACT_LOAD;
    logic [3:0]  op_code    = OP_WRITE;
    logic [7:0]  word_addr  = 8'h00;
    logic [7:0]  write_data = 8'h00;
    logic [7:0]  rx_byte    = 8'h00;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        ctl_valid;
    logic        start_bit;
    logic        stop_bit;
    logic        ack_valid;
    logic        ack_bit;
    logic [15:0] read_value;
    logic        done_res;

    // Predicted sequencer state
    logic [3:0]  seq_phase = PH_IDLE;
    logic [3:0]  seq_op    = OP_WRITE;
    logic [7:0]  seq_addr  = 8'h00;
    logic [7:0]  seq_data  = 8'h00;
    logic [15:0] seq_word  = 16'h0000;

    seq_res_t pending_drives[$];

    int send_idle_pct   = 0;
    int rx_stall_pct    = 0;
    int words_sent      = 0;
    int loads_sent      = 0;
    int results_checked = 0;
    int transfers_done  = 0;
    int errors          = 0;

    i2c_sensor_transfer_sequencer dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .op_code    (op_code),
        .word_addr  (word_addr),
        .write_data (write_data),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .ctl_valid  (ctl_valid),
        .start_bit  (start_bit),
        .stop_bit   (stop_bit),
        .ack_valid  (ack_valid),
        .ack_bit    (ack_bit),
        .read_value (read_value),
        .done_res   (done_res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance the predicted state by one word and return the bus drive it gives.
    // The phase nibble gains one bit per step: idle, address, data, last, finished.
    function automatic seq_res_t sequence_step(input logic act, input logic [3:0] op,
                                               input logic [7:0] addr,
                                               input logic [7:0] data,
                                               input logic [7:0] rx);
        seq_res_t r;
        r = '0;
        if (act == ACT_LOAD)
        begin
            seq_op    = op;
            seq_phase = PH_IDLE;
            seq_addr  = addr;
            seq_data  = data;
            seq_word  = 16'h0000;
        end
        else
        begin
            unique case (seq_op)
                OP_WRITE:
                    unique case (seq_phase)
                        PH_IDLE:
                        begin
                            r.ctl_valid = 1'b1;
                            r.tx_valid  = 1'b1;
                            r.tx_byte   = ADDR_WR;
                            seq_phase   = PH_ADDR;
                        end
                        PH_ADDR:
                        begin
                            r.ctl_valid = 1'b1;
                            r.tx_valid  = 1'b1;
                            r.tx_byte   = seq_addr;
                            seq_phase   = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            r.ctl_valid = 1'b1;
                            r.tx_valid  = 1'b1;
                            r.tx_byte   = seq_data;
                            seq_phase   = PH_LAST;
                        end
                        PH_LAST:
                        begin
                            r.ctl_valid = 1'b1;
                            r.stop_bit  = 1'b1;
                            seq_phase   = PH_FIN;
                        end
                        default: ;
                    endcase
                OP_CUR_READ:
                    unique case (seq_phase)
                        PH_IDLE:
                        begin
                            r.ctl_valid = 1'b1;
                            r.tx_valid  = 1'b1;
                            r.tx_byte   = ADDR_RD;
                            seq_phase   = PH_ADDR;
                        end
                        PH_ADDR:
                        begin
                            r.ctl_valid = 1'b1;
                            r.ack_valid = 1'b1;
                            r.ack_bit   = 1'b1;
                            seq_phase   = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            r.ctl_valid    = 1'b1;
                            r.ack_valid    = 1'b1;
                            r.ack_bit      = 1'b1;
                            seq_word[15:8] = rx;
                            seq_phase      = PH_LAST;
                        end
                        PH_LAST:
                        begin
                            // not-acknowledge the second byte and stop
                            r.ctl_valid   = 1'b1;
                            r.stop_bit    = 1'b1;
                            r.ack_valid   = 1'b1;
                            seq_word[7:0] = rx;
                            seq_phase     = PH_FIN;
                        end
                        default: ;
                    endcase
                OP_RAND_READ:
                    unique case (seq_phase)
                        PH_IDLE:
                        begin
                            r.ctl_valid = 1'b1;
                            r.tx_valid  = 1'b1;
                            r.tx_byte   = ADDR_WR;
                            seq_phase   = PH_ADDR;
                        end
                        PH_ADDR:
                        begin
                            r.ctl_valid = 1'b1;
                            r.tx_valid  = 1'b1;
                            r.tx_byte   = seq_addr;
                            seq_phase   = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            // repeated start, then carry on as a current-address read
                            r.ctl_valid = 1'b1;
                            r.start_bit = 1'b1;
                            seq_op      = OP_CUR_READ;
                            seq_phase   = PH_IDLE;
                        end
                        default: ;
                    endcase
                default:
                begin
                    seq_op    = OP_WRITE;
                    seq_phase = PH_ABORT;
                end
            endcase
        end
        r.read_value = seq_word;
        r.done_res   = seq_phase[3];
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Present one word, idling first at the current rate, and hold it until taken.
    task automatic send_word(input logic act, input logic [3:0] op, input logic [7:0] addr,
                             input logic [7:0] data, input logic [7:0] rx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        op_code    <= op;
        word_addr  <= addr;
        write_data <= data;
        rx_byte    <= rx;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        words_sent++;
        if (act == ACT_LOAD)
            loads_sent++;
    endtask

    task automatic load_command(input logic [3:0] op, input logic [7:0] addr,
                                input logic [7:0] data);
        send_word(ACT_LOAD, op, addr, data, 8'($urandom_range(255)));
    endtask

    task automatic bus_event(input logic [7:0] rx);
        send_word(ACT_EVENT, 4'($urandom_range(15)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), rx);
    endtask

    // Events before any command run a byte write of address and data zero
    task automatic test_reset_state();
        bus_event(8'h00);
        bus_event(8'hff);
    endtask

    task automatic test_byte_write();
        load_command(OP_WRITE, 8'hff, 8'h00);
        bus_event(8'h00);
        bus_event(8'hff);
        bus_event(8'h00);
        bus_event(8'hff);
        // finished transfer: nothing driven, nothing changes
        bus_event(8'h00);
    endtask

    task automatic test_current_read();
        load_command(OP_CUR_READ, 8'h00, 8'hff);
        bus_event(8'hff);
        bus_event(8'h00);
        bus_event(8'hff);
        bus_event(8'h00);
    endtask

    task automatic test_random_read();
        load_command(OP_RAND_READ, 8'h00, 8'h81);
        bus_event(8'h00);
        bus_event(8'hff);
        bus_event(8'h00);
        bus_event(8'h00);
        bus_event(8'h00);
        bus_event(8'h5a);
        bus_event(8'ha5);
    endtask

    // Unknown codes abort on the first event; later events match no phase
    task automatic test_invalid_op();
        load_command(OP_BAD_HIGH, 8'h55, 8'haa);
        bus_event(8'h81);
        load_command(OP_BAD_LOW, 8'haa, 8'h55);
        bus_event(8'h7e);
    endtask

    // Mostly whole transfers with random content; some cut short by a fresh
    // command, some overrun, and a sprinkling of stray events.
    task automatic test_random_transfers(input int n_words, input int idle_pct,
                                         input int stall_pct);
        int         stop_at;
        int         roll;
        int         steps;
        logic [3:0] op;
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
        stop_at       = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 6)
                bus_event(8'($urandom_range(255)));
            else
            begin
                op = (roll < 88) ? 4'($urandom_range(2)) : 4'($urandom_range(15));
                unique case (op)
                    OP_WRITE, OP_CUR_READ: steps = 4;
                    OP_RAND_READ:          steps = 7;
                    default:               steps = 1;
                endcase
                roll = $urandom_range(99);
                if (roll < 10)
                    steps = $urandom_range(steps - 1);
                else if (roll < 20)
                    steps += $urandom_range(2, 1);
                load_command(op, 8'($urandom_range(255)), 8'($urandom_range(255)));
                repeat (steps)
                    bus_event(8'($urandom_range(255)));
            end
        end
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < rx_stall_pct);

    // Check results first so that a result can never be matched against the
    // prediction for a word taken in the same cycle.
    always @(posedge clk)
    begin
        seq_res_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_drives.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result word with nothing pending", $time);
                end
                else
                begin
                    want = pending_drives.pop_front();
                    compare_field("tx_valid",   16'(want.tx_valid),  16'(tx_valid));
                    compare_field("tx_byte",    16'(want.tx_byte),   16'(tx_byte));
                    compare_field("ctl_valid",  16'(want.ctl_valid), 16'(ctl_valid));
                    compare_field("start_bit",  16'(want.start_bit), 16'(start_bit));
                    compare_field("stop_bit",   16'(want.stop_bit),  16'(stop_bit));
                    compare_field("ack_valid",  16'(want.ack_valid), 16'(ack_valid));
                    compare_field("ack_bit",    16'(want.ack_bit),   16'(ack_bit));
                    compare_field("read_value", want.read_value,     read_value);
                    compare_field("done_res",   16'(want.done_res),  16'(done_res));
                    results_checked++;
                    if (want.done_res && want.stop_bit)
                        transfers_done++;
                end
            end
            if (in_valid && !in_stall)
                pending_drives.push_back(sequence_step(action, op_code, word_addr,
                                                       write_data, rx_byte));
        end
    end

    initial
    begin
        #2_000_000;
        $display("Run did not finish in time, %0d results still pending",
                 pending_drives.size());
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int guard;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_byte_write();
        test_current_read();
        test_random_read();
        test_invalid_op();

        test_random_transfers(RANDOM_WORDS_PER_PHASE, 0, 0);
        test_random_transfers(RANDOM_WORDS_PER_PHASE, 74, 0);
        test_random_transfers(RANDOM_WORDS_PER_PHASE, 0, 74);
        test_random_transfers(RANDOM_WORDS_PER_PHASE, 23, 23);

        // drop valid and let the last results drain
        in_valid <= 1'b0;
        guard = 0;
        while (pending_drives.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_drives.size() != 0)
        begin
            errors++;
            $display("%0t ns: %0d results never arrived", $time, pending_drives.size());
        end

        $display("Sent %0d words (%0d command loads, %0d bus events) under four pacing mixes;",
                 words_sent, loads_sent, words_sent - loads_sent);
        $display("checked %0d result words, %0d transfers ended with a stop, %0d errors.",
                 results_checked, transfers_done, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
